[src/cdlru_pkg.sv]
// ----------------------------------------------------------------------------
// cdlru_pkg: shared types and constants for the clean/dirty LRU policy
// Entry count, link encoding, request and status codes, beat structs.
// ----------------------------------------------------------------------------
package cdlru_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int ID_W    = 10;

    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_HIT    = 2'd1;
    localparam logic [1:0] MODE_EVICT  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] entry_id;
        logic            dirty;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0] victim_id;
        logic [1:0]      status;
    } out_beat_t;

    function automatic logic is_idx(input logic [LINK_W-1:0] v);
        return 32'(v) < ENTRIES;
    endfunction

endpackage

[src/clean_dirty_lru_policy.sv]
// ----------------------------------------------------------------------------
// clean_dirty_lru_policy: split clean/dirty LRU replacement list manager
//
// Input channel s_*: one request beat (insert, hit or evict) with an entry
// id and a dirty bit. Output channel m_*: exactly one result beat per
// request, carrying the victim id and a status code.
// The next/prev links live in two 1024-entry synchronous RAMs with a
// registered read port; head and tail pointers are flip-flops.
// Steps: insert runs relink, then head if its list is not empty; hit adds
// check first; evict runs check, relink; failures skip on to done.
// One request is in work at a time; the RAM read, the unlink writes and
// the relink writes are separate steps of the sequencer, so a new request
// is taken only after the last one has left the sequencer.
// The result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, a finished request holds in its
// last step until the output register frees.
// After reset both RAMs are swept to null, one entry per cycle, over all
// 1024 entries; s_ready stays low during the sweep.
// ----------------------------------------------------------------------------
module clean_dirty_lru_policy (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cdlru_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cdlru_pkg::out_beat_t m_data
);
    import cdlru_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_RELINK = 6'b001000,
        S_HEAD   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [1:0]        mode_reg, mode_next;
    logic              dsel_reg, dsel_next;
    logic [LINK_W-1:0] tgt_reg, tgt_next;
    logic [1:0]        status_reg, status_next;
    logic [ID_W-1:0]   victim_reg, victim_next;
    logic [LINK_W-1:0] clean_head_reg, clean_head_next, clean_tail_reg, clean_tail_next;
    logic [LINK_W-1:0] dirty_head_reg, dirty_head_next, dirty_tail_reg, dirty_tail_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    logic [LINK_W-1:0] next_mem [ENTRIES];
    logic [LINK_W-1:0] prev_mem [ENTRIES];
    logic [LINK_W-1:0] next_rd_reg, prev_rd_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              nx_we, pv_we;
    logic [IDX_W-1:0]  nx_waddr, pv_waddr;
    logic [LINK_W-1:0] nx_wdata, pv_wdata;

    logic              accept, id_ok;
    logic [LINK_W-1:0] id_link, pick, sel_head;
    logic              p_idx, n_idx, hc, hd, tc, td, links_ok;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign id_ok    = 32'(s_data.entry_id) < ENTRIES;
    assign id_link  = LINK_W'(s_data.entry_id);
    assign pick     = s_data.dirty ? (is_idx(dirty_tail_reg) ? dirty_tail_reg : clean_tail_reg)
                                   : (is_idx(clean_tail_reg) ? clean_tail_reg : dirty_tail_reg);
    assign sel_head = dsel_reg ? dirty_head_reg : clean_head_reg;

    assign p_idx    = is_idx(prev_rd_reg);
    assign n_idx    = is_idx(next_rd_reg);
    assign hc       = (clean_head_reg == tgt_reg);
    assign hd       = (dirty_head_reg == tgt_reg);
    assign tc       = (clean_tail_reg == tgt_reg);
    assign td       = (dirty_tail_reg == tgt_reg);
    assign links_ok = (p_idx || hc || hd) && (n_idx || tc || td);

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (rd_en) begin
            next_rd_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (rd_en) begin
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mode_next       = mode_reg;
        dsel_next       = dsel_reg;
        tgt_next        = tgt_reg;
        status_next     = status_reg;
        victim_next     = victim_reg;
        clean_head_next = clean_head_reg;
        clean_tail_next = clean_tail_reg;
        dirty_head_next = dirty_head_reg;
        dirty_tail_next = dirty_tail_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        nx_we           = 1'b0;
        nx_waddr        = '0;
        nx_wdata        = NULL_LINK;
        pv_we           = 1'b0;
        pv_waddr        = '0;
        pv_wdata        = NULL_LINK;

        unique case (state_reg)
            S_CLEAR: begin
                nx_we        = 1'b1;
                pv_we        = 1'b1;
                nx_waddr     = clr_cnt_reg;
                pv_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == ENTRIES - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    mode_next   = s_data.mode;
                    dsel_next   = s_data.dirty;
                    status_next = STATUS_OK;
                    victim_next = '0;
                    unique case (s_data.mode)
                        MODE_INSERT: begin
                            tgt_next = id_link;
                            if (id_ok) begin
                                state_next = S_RELINK;
                            end else begin
                                status_next = STATUS_BAD;
                                state_next  = S_DONE;
                            end
                        end
                        MODE_HIT: begin
                            tgt_next = id_link;
                            rd_addr  = id_link[IDX_W-1:0];
                            if (id_ok) begin
                                rd_en      = 1'b1;
                                state_next = S_CHECK;
                            end else begin
                                status_next = STATUS_BAD;
                                state_next  = S_DONE;
                            end
                        end
                        MODE_EVICT: begin
                            tgt_next = pick;
                            rd_addr  = pick[IDX_W-1:0];
                            if (is_idx(pick)) begin
                                rd_en      = 1'b1;
                                state_next = S_CHECK;
                            end else begin
                                status_next = STATUS_EMPTY;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (!links_ok) begin
                    status_next = STATUS_BAD;
                    state_next  = S_DONE;
                end else begin
                    if (p_idx) begin
                        nx_we    = 1'b1;
                        nx_waddr = prev_rd_reg[IDX_W-1:0];
                        nx_wdata = next_rd_reg;
                    end else if (hc) begin
                        clean_head_next = next_rd_reg;
                    end else begin
                        dirty_head_next = next_rd_reg;
                    end
                    if (n_idx) begin
                        pv_we    = 1'b1;
                        pv_waddr = next_rd_reg[IDX_W-1:0];
                        pv_wdata = prev_rd_reg;
                    end else if (tc) begin
                        clean_tail_next = prev_rd_reg;
                    end else begin
                        dirty_tail_next = prev_rd_reg;
                    end
                    state_next = S_RELINK;
                end
            end
            S_RELINK: begin
                nx_waddr = tgt_reg[IDX_W-1:0];
                pv_waddr = tgt_reg[IDX_W-1:0];
                if (mode_reg == MODE_EVICT) begin
                    nx_we       = 1'b1;
                    pv_we       = 1'b1;
                    victim_next = ID_W'(tgt_reg);
                    state_next  = S_DONE;
                end else if (is_idx(sel_head)) begin
                    nx_we      = 1'b1;
                    nx_wdata   = sel_head;
                    pv_we      = 1'b1;
                    state_next = S_HEAD;
                end else begin
                    nx_we = (mode_reg == MODE_HIT);
                    pv_we = (mode_reg == MODE_HIT);
                    if (dsel_reg) begin
                        dirty_head_next = tgt_reg;
                        dirty_tail_next = tgt_reg;
                    end else begin
                        clean_head_next = tgt_reg;
                        clean_tail_next = tgt_reg;
                    end
                    state_next = S_DONE;
                end
            end
            S_HEAD: begin
                pv_we    = 1'b1;
                pv_waddr = sel_head[IDX_W-1:0];
                pv_wdata = tgt_reg;
                if (dsel_reg) begin
                    dirty_head_next = tgt_reg;
                end else begin
                    clean_head_next = tgt_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.victim_id = victim_reg;
                    m_data_next.status    = status_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clean_head_reg <= NULL_LINK;
            clean_tail_reg <= NULL_LINK;
            dirty_head_reg <= NULL_LINK;
            dirty_tail_reg <= NULL_LINK;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clean_head_reg <= clean_head_next;
            clean_tail_reg <= clean_tail_next;
            dirty_head_reg <= dirty_head_next;
            dirty_tail_reg <= dirty_tail_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        dsel_reg   <= dsel_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        victim_reg <= victim_next;
        m_data_reg <= m_data_next;
    end

endmodule

[src/cdlru_checker.sv]
// ----------------------------------------------------------------------------
// cdlru_checker: port-level checks for the clean/dirty LRU policy
// Watches both channels and flags protocol and result-code slips.
// ----------------------------------------------------------------------------
module cdlru_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input cdlru_pkg::in_beat_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input cdlru_pkg::out_beat_t m_data
);
    import cdlru_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request beat changed while waiting");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.victim_id == '0)
        else $error("victim id set on failed request");

    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during link sweep");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

endmodule

bind clean_dirty_lru_policy cdlru_checker u_cdlru_checker (.*);
